// ----- rtl/model_matrix_from_trs_macros.svh -----
// Assertion macros shared by the model_matrix_from_trs RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef MODEL_MATRIX_FROM_TRS_MACROS_SVH
`define MODEL_MATRIX_FROM_TRS_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MMTRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mmtrs check failed");
`define MMTRS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("mmtrs check failed");
`else
`define MMTRS_ASSERT(lbl, prop)
`define MMTRS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/mmtrs_pkg.sv -----
// Types, constants and arithmetic helpers for the TRS model matrix block.
// No dependencies.
package mmtrs_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned CordSteps = 18;
  localparam int unsigned XyW       = 34;
  localparam int unsigned ZW        = 26;
  localparam int unsigned ZinW      = 23;
  localparam int unsigned RotW      = 34;
  localparam int unsigned RW        = 35;
  localparam int unsigned PrdW      = RW + WordW;
  localparam int unsigned AngLat    = 2;
  localparam int unsigned CorLat    = CordSteps + 1;
  localparam int unsigned NumOut    = 12;

  // 92 full turns: lifts every input angle above zero
  localparam logic signed [33:0] TurnBias   = 34'sd2170552320;
  localparam logic [14:0]        RecipMul   = 15'd23302;
  localparam int unsigned        RecipShift = 20;
  localparam logic [15:0]        QuarterDiv = 16'd45;
  localparam logic signed [XyW-1:0] CordGain = 34'sd652032874;

  localparam logic [1:0] Quad0 = 2'd0;
  localparam logic [1:0] Quad1 = 2'd1;
  localparam logic [1:0] Quad2 = 2'd2;

  typedef logic signed [WordW-1:0] word_t;

  typedef struct packed {
    word_t [2:0] pos;
    word_t [2:0] scale;
  } side_t;

  typedef struct packed {
    logic [1:0]      quad;
    logic [ZinW-1:0] z;
  } ang_t;

  typedef struct packed {
    word_t c;
    word_t s;
  } trig_t;

  typedef logic signed [PrdW-1:0] prod_t;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q2.30 product, rounded to nearest with ties up
  function automatic logic signed [RotW-1:0] mul30(input logic signed [RotW-1:0] a,
                                                   input logic signed [RotW-1:0] b);
    logic signed [2*RotW-1:0] p;
    p = a * b + 68'sd536870912;
    return p[RotW+29:30];
  endfunction

endpackage

// ----- rtl/mmtrs_angle.sv -----
// Angle reduction: Q16.16 degrees to quadrant and remainder below 90 degrees.
// Depends on mmtrs_pkg.
module mmtrs_angle (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  mmtrs_pkg::word_t    angle_i,
  output logic                valid_o,
  output mmtrs_pkg::ang_t     ang_o
);
  import mmtrs_pkg::*;

  logic signed [33:0] u;
  logic [15:0]        hi;
  logic [30:0]        prod_d, prod_q;
  logic [15:0]        hi_q;
  logic [16:0]        lo_q;
  logic               v1_q, v2_q;
  logic [10:0]        quo;
  logic [15:0]        rem;
  ang_t               ang_d, ang_q;

  always_comb begin
    u      = {{2{angle_i[WordW-1]}}, angle_i} + TurnBias;
    hi     = u[32:17];
    prod_d = 31'(hi) * 31'(RecipMul);
  end

  always_comb begin
    quo        = prod_q[30:RecipShift];
    rem        = hi_q - 16'(quo) * QuarterDiv;
    ang_d.quad = quo[1:0];
    ang_d.z    = {rem[5:0], lo_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      hi_q   <= hi;
      lo_q   <= u[16:0];
      ang_q  <= ang_d;
    end
  end

  assign valid_o = v2_q;
  assign ang_o   = ang_q;

endmodule

// ----- rtl/mmtrs_cordic.sv -----
// Pipelined rotation CORDIC in degrees, one step per stage, then quadrant fold.
// Depends on mmtrs_pkg.
module mmtrs_cordic (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  mmtrs_pkg::ang_t  ang_i,
  output logic             valid_o,
  output mmtrs_pkg::trig_t trig_o
);
  import mmtrs_pkg::*;

  logic signed [XyW-1:0] xi [CordSteps];
  logic signed [XyW-1:0] yi [CordSteps];
  logic signed [ZW-1:0]  zi [CordSteps];
  logic signed [XyW-1:0] xn [CordSteps];
  logic signed [XyW-1:0] yn [CordSteps];
  logic signed [ZW-1:0]  zn [CordSteps];
  logic signed [XyW-1:0] x_q [CordSteps];
  logic signed [XyW-1:0] y_q [CordSteps];
  logic signed [ZW-1:0]  z_q [CordSteps];
  logic [1:0]            quad_q [CordSteps];
  logic [CordSteps-1:0]  vld_q;
  logic                  fold_vld_q;
  trig_t                 trig_d, trig_q;
  logic signed [XyW-1:0] xl, yl;

  always_comb begin
    for (int i = 0; i < CordSteps; i++) begin
      if (i == 0) begin
        xi[i] = CordGain;
        yi[i] = '0;
        zi[i] = ZW'({1'b0, ang_i.z});
      end else begin
        xi[i] = x_q[i-1];
        yi[i] = y_q[i-1];
        zi[i] = z_q[i-1];
      end
      if (!zi[i][ZW-1]) begin
        xn[i] = xi[i] - (yi[i] >>> i);
        yn[i] = yi[i] + (xi[i] >>> i);
        zn[i] = zi[i] - atan_deg(5'(i));
      end else begin
        xn[i] = xi[i] + (yi[i] >>> i);
        yn[i] = yi[i] - (xi[i] >>> i);
        zn[i] = zi[i] + atan_deg(5'(i));
      end
    end
  end

  always_comb begin
    xl = x_q[CordSteps-1];
    yl = y_q[CordSteps-1];
    case (quad_q[CordSteps-1])
      Quad0: begin
        trig_d.c = WordW'(xl);
        trig_d.s = WordW'(yl);
      end
      Quad1: begin
        trig_d.c = WordW'(-yl);
        trig_d.s = WordW'(xl);
      end
      Quad2: begin
        trig_d.c = WordW'(-xl);
        trig_d.s = WordW'(-yl);
      end
      default: begin
        trig_d.c = WordW'(yl);
        trig_d.s = WordW'(-xl);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      fold_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q      <= {vld_q[CordSteps-2:0], valid_i};
      fold_vld_q <= vld_q[CordSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < CordSteps; i++) begin
        x_q[i]    <= xn[i];
        y_q[i]    <= yn[i];
        z_q[i]    <= zn[i];
        quad_q[i] <= (i == 0) ? ang_i.quad : quad_q[(i == 0) ? 0 : i-1];
      end
      trig_q <= trig_d;
    end
  end

  assign valid_o = fold_vld_q;
  assign trig_o  = trig_q;

endmodule

// ----- rtl/mmtrs_mat.sv -----
// Rotation products, sums and scaling: four register stages.
// Depends on mmtrs_pkg.
module mmtrs_mat (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  mmtrs_pkg::trig_t      trig_x_i,
  input  mmtrs_pkg::trig_t      trig_y_i,
  input  mmtrs_pkg::trig_t      trig_z_i,
  input  mmtrs_pkg::side_t      side_i,
  output logic                  valid_o,
  output mmtrs_pkg::prod_t [8:0] prod_o,
  output mmtrs_pkg::side_t      side_o
);
  import mmtrs_pkg::*;

  logic signed [RotW-1:0] cx, sx, cy, sy, cz, sz;
  logic [3:0] vld_q;

  // stage 1
  logic signed [RotW-1:0] sysx_q, cysx_q, cycz_q, cysz_q, sycx_q;
  logic signed [RotW-1:0] cxsz_q, cxcz_q, sycz_q, sysz_q, cycx_q;
  logic signed [RotW-1:0] sz1_q, cz1_q, sx1_q;
  side_t                  side1_q;
  // stage 2
  logic signed [RotW-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [RotW-1:0] cycz2_q, cysz2_q, sycx2_q, cxsz2_q, cxcz2_q;
  logic signed [RotW-1:0] sycz2_q, sysz2_q, cycx2_q, sx2_q;
  side_t                  side2_q;
  // stage 3
  logic signed [RW-1:0]   r_d [9];
  logic signed [RW-1:0]   r_q [9];
  side_t                  side3_q;
  // stage 4
  prod_t [8:0]            prod_d, prod_q;
  side_t                  side4_q;

  always_comb begin
    cx = RotW'(trig_x_i.c);
    sx = RotW'(trig_x_i.s);
    cy = RotW'(trig_y_i.c);
    sy = RotW'(trig_y_i.s);
    cz = RotW'(trig_z_i.c);
    sz = RotW'(trig_z_i.s);
  end

  always_comb begin
    r_d[0] = RW'(cycz2_q) + RW'(pa_q);
    r_d[1] = RW'(pb_q) - RW'(cysz2_q);
    r_d[2] = RW'(sycx2_q);
    r_d[3] = RW'(cxsz2_q);
    r_d[4] = RW'(cxcz2_q);
    r_d[5] = -RW'(sx2_q);
    r_d[6] = RW'(pc_q) - RW'(sycz2_q);
    r_d[7] = RW'(sysz2_q) + RW'(pd_q);
    r_d[8] = RW'(cycx2_q);
  end

  always_comb begin
    for (int row = 0; row < 3; row++) begin
      for (int col = 0; col < 3; col++) begin
        prod_d[row*3+col] = PrdW'(r_q[row*3+col]) * PrdW'(side3_q.scale[col]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sysx_q  <= mul30(sy, sx);
      cysx_q  <= mul30(cy, sx);
      cycz_q  <= mul30(cy, cz);
      cysz_q  <= mul30(cy, sz);
      sycx_q  <= mul30(sy, cx);
      cxsz_q  <= mul30(cx, sz);
      cxcz_q  <= mul30(cx, cz);
      sycz_q  <= mul30(sy, cz);
      sysz_q  <= mul30(sy, sz);
      cycx_q  <= mul30(cy, cx);
      sz1_q   <= sz;
      cz1_q   <= cz;
      sx1_q   <= sx;
      side1_q <= side_i;

      pa_q    <= mul30(sysx_q, sz1_q);
      pb_q    <= mul30(sysx_q, cz1_q);
      pc_q    <= mul30(cysx_q, sz1_q);
      pd_q    <= mul30(cysx_q, cz1_q);
      cycz2_q <= cycz_q;
      cysz2_q <= cysz_q;
      sycx2_q <= sycx_q;
      cxsz2_q <= cxsz_q;
      cxcz2_q <= cxcz_q;
      sycz2_q <= sycz_q;
      sysz2_q <= sysz_q;
      cycx2_q <= cycx_q;
      sx2_q   <= sx1_q;
      side2_q <= side1_q;

      for (int k = 0; k < 9; k++) begin
        r_q[k] <= r_d[k];
      end
      side3_q <= side2_q;

      prod_q  <= prod_d;
      side4_q <= side3_q;
    end
  end

  assign valid_o = vld_q[3];
  assign prod_o  = prod_q;
  assign side_o  = side4_q;

endmodule

// ----- rtl/model_matrix_from_trs.sv -----
// Top level of the TRS model matrix block: input stage, angle and CORDIC lanes,
// matrix pipeline, rounding and output skid. Depends on mmtrs_pkg and the macros.
//
// Takes one word per cycle while in_stall_o is low and gives one word per cycle
// while out_stall_i is low. Behind the input register come 2 reduction stages,
// 18 CORDIC stages plus a quadrant fold, 4 matrix stages and the output register.
// The whole pipeline advances together and holds only while the output skid
// register is full, which is what in_stall_o shows.
`include "model_matrix_from_trs_macros.svh"
module model_matrix_from_trs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mmtrs_pkg::word_t pos_x_i,
  input  mmtrs_pkg::word_t pos_y_i,
  input  mmtrs_pkg::word_t pos_z_i,
  input  mmtrs_pkg::word_t angle_x_i,
  input  mmtrs_pkg::word_t angle_y_i,
  input  mmtrs_pkg::word_t angle_z_i,
  input  mmtrs_pkg::word_t scale_x_i,
  input  mmtrs_pkg::word_t scale_y_i,
  input  mmtrs_pkg::word_t scale_z_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mmtrs_pkg::word_t m00_o,
  output mmtrs_pkg::word_t m01_o,
  output mmtrs_pkg::word_t m02_o,
  output mmtrs_pkg::word_t m10_o,
  output mmtrs_pkg::word_t m11_o,
  output mmtrs_pkg::word_t m12_o,
  output mmtrs_pkg::word_t m20_o,
  output mmtrs_pkg::word_t m21_o,
  output mmtrs_pkg::word_t m22_o,
  output mmtrs_pkg::word_t trans_x_o,
  output mmtrs_pkg::word_t trans_y_o,
  output mmtrs_pkg::word_t trans_z_o
);
  import mmtrs_pkg::*;

  localparam int unsigned SideDly = AngLat + CorLat;

  logic          en;
  logic          s0_vld_q;
  word_t [2:0]   ang_q;
  side_t         side0_q;
  side_t         side_dly_q [SideDly];

  logic  [2:0]   ang_vld;
  ang_t  [2:0]   ang_red;
  logic  [2:0]   cor_vld;
  trig_t [2:0]   trig;

  logic          mat_vld;
  prod_t [8:0]   mat_prod;
  side_t         mat_side;

  word_t [NumOut-1:0] res_d, out_q, skid_q;
  logic               out_vld_q, skid_vld_q;
  logic signed [PrdW-1:0] rnd;
  logic signed [PrdW-31:0] shv;

  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q         <= {angle_z_i, angle_y_i, angle_x_i};
      side0_q.pos   <= {pos_z_i, pos_y_i, pos_x_i};
      side0_q.scale <= {scale_z_i, scale_y_i, scale_x_i};
      for (int i = 0; i < SideDly; i++) begin
        side_dly_q[i] <= (i == 0) ? side0_q : side_dly_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    mmtrs_angle u_angle (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (s0_vld_q),
      .angle_i (ang_q[g]),
      .valid_o (ang_vld[g]),
      .ang_o   (ang_red[g])
    );
    mmtrs_cordic u_cordic (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (ang_vld[g]),
      .ang_i   (ang_red[g]),
      .valid_o (cor_vld[g]),
      .trig_o  (trig[g])
    );
  end

  mmtrs_mat u_mat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (cor_vld[0]),
    .trig_x_i (trig[0]),
    .trig_y_i (trig[1]),
    .trig_z_i (trig[2]),
    .side_i   (side_dly_q[SideDly-1]),
    .valid_o  (mat_vld),
    .prod_o   (mat_prod),
    .side_o   (mat_side)
  );

  always_comb begin
    rnd = '0;
    shv = '0;
    for (int k = 0; k < 9; k++) begin
      rnd = mat_prod[k] + PrdW'(64'sd536870912);
      shv = rnd[PrdW-1:30];
      if (shv > (PrdW-30)'(64'sd2147483647)) begin
        res_d[k] = 32'sh7FFFFFFF;
      end else if (shv < -(PrdW-30)'(64'sd2147483648)) begin
        res_d[k] = 32'sh80000000;
      end else begin
        res_d[k] = WordW'(shv);
      end
    end
    for (int k = 0; k < 3; k++) begin
      res_d[9+k] = mat_side.pos[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (!out_stall_i) begin
        skid_vld_q <= 1'b0;
      end
    end else if (mat_vld) begin
      if (out_vld_q && out_stall_i) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (!out_stall_i) begin
        out_q <= skid_q;
      end
    end else if (mat_vld) begin
      if (out_vld_q && out_stall_i) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign m00_o       = out_q[0];
  assign m01_o       = out_q[1];
  assign m02_o       = out_q[2];
  assign m10_o       = out_q[3];
  assign m11_o       = out_q[4];
  assign m12_o       = out_q[5];
  assign m20_o       = out_q[6];
  assign m21_o       = out_q[7];
  assign m22_o       = out_q[8];
  assign trans_x_o   = out_q[9];
  assign trans_y_o   = out_q[10];
  assign trans_z_o   = out_q[11];

  `MMTRS_ASSERT(a_skid_has_out, skid_vld_q |-> out_vld_q)
  `MMTRS_ASSERT(a_skid_fill, $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i))
  `MMTRS_ASSERT(a_pipe_frozen, skid_vld_q |=> $stable(mat_vld))
  `MMTRS_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_vld_q && !skid_vld_q)

endmodule
